/* src/scfp_pkg.sv */
// shared constants, types and codes for the servo command frame parser
package scfp_pkg;

  // frame geometry
  localparam int FRAME_LEN    = 6;
  localparam int NUM_CHANNELS = 3;
  localparam int CNT_W        = $clog2(FRAME_LEN + 1);

  // only the header, position and channel bytes are ever looked at
  localparam int HDR_IDX    = 0;
  localparam int POS_HI_IDX = 1;
  localparam int POS_LO_IDX = 2;
  localparam int CHAN_IDX   = 3;
  localparam int KEEP_BYTES = 4;
  localparam int KEEP_IDX_W = $clog2(KEEP_BYTES);

  // character constants
  localparam logic [7:0] HDR_CHAR   = 8'h48;  // 'H'
  localparam logic [7:0] DIGIT_BASE = 8'h31;  // '1'

  // transaction codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  localparam logic EV_UPDATE  = 1'b0;
  localparam logic EV_DISCARD = 1'b1;

  typedef logic [KEEP_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             activity;
  } ctl_t;

  typedef struct packed {
    logic        event_res;
    logic [1:0]  channel;
    logic [15:0] position;
  } result_t;

  typedef struct packed {
    ctl_t                  ctl;
    logic                  wr_en;
    logic [KEEP_IDX_W-1:0] wr_idx;
    logic                  res_valid;
    result_t               res;
  } dec_t;

endpackage

/* src/scfp_decode.sv */
// next-state and result logic for one accepted transaction
module scfp_decode (
  input  logic                 opcode,
  input  logic [7:0]           data_byte,
  input  scfp_pkg::ctl_t       ctl,
  input  scfp_pkg::frame_t     frame,
  output scfp_pkg::dec_t       dec
);

  scfp_pkg::frame_t view;
  logic [7:0]       chan_full;
  logic             last_byte;
  logic             frame_ok;

  always_comb begin
    // merge the incoming byte so a short frame decodes on its last byte
    for (int i = 0; i < scfp_pkg::KEEP_BYTES; i++) begin
      if (ctl.count == scfp_pkg::CNT_W'(i)) begin
        view[i] = data_byte;
      end else begin
        view[i] = frame[i];
      end
    end
  end

  assign chan_full = view[scfp_pkg::CHAN_IDX] - scfp_pkg::DIGIT_BASE;
  assign last_byte = (ctl.count == scfp_pkg::CNT_W'(scfp_pkg::FRAME_LEN - 1));
  assign frame_ok  = (view[scfp_pkg::HDR_IDX] == scfp_pkg::HDR_CHAR)
                  && (view[scfp_pkg::CHAN_IDX] >= scfp_pkg::DIGIT_BASE)
                  && (chan_full < 8'(scfp_pkg::NUM_CHANNELS));

  always_comb begin
    dec           = '0;
    dec.ctl       = ctl;
    dec.wr_idx    = ctl.count[scfp_pkg::KEEP_IDX_W-1:0];
    case (opcode)
      scfp_pkg::OP_BYTE: begin
        dec.wr_en        = (ctl.count < scfp_pkg::CNT_W'(scfp_pkg::KEEP_BYTES));
        dec.ctl.activity = 1'b1;
        if (last_byte) begin
          dec.ctl.count = '0;
          if (frame_ok) begin
            dec.res_valid        = 1'b1;
            dec.res.event_res    = scfp_pkg::EV_UPDATE;
            dec.res.channel      = chan_full[1:0];
            dec.res.position     = {view[scfp_pkg::POS_HI_IDX], view[scfp_pkg::POS_LO_IDX]};
          end
        end else begin
          dec.ctl.count = ctl.count + 1'b1;
        end
      end
      scfp_pkg::OP_POLL: begin
        if (ctl.activity) begin
          dec.ctl.activity = 1'b0;
        end else if (ctl.count != '0) begin
          dec.ctl.count     = '0;
          dec.res_valid     = 1'b1;
          dec.res.event_res = scfp_pkg::EV_DISCARD;
        end
      end
      default: begin
        dec.ctl = ctl;
      end
    endcase
  end

endmodule

/* src/servo_command_frame_parser.sv */
// servo command frame parser top level: frame store, control state and output skid
// a result is registered in the output slot, or in the skid slot while the output is stalled
// throughput: one transaction per cycle while in_stall is low; the decode is a single pass of compare logic
// in_stall is high exactly while the skid slot is full
// reset: synchronous active-low rst_n clears the byte count, activity flag and
// both output slots; stored frame bytes are left as they are
module servo_command_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_data_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_event_res,
  output logic [1:0]  out_channel,
  output logic [15:0] out_position
);

  // control state: bytes held and activity since last poll
  scfp_pkg::ctl_t   ctl_r;
  // only the bytes that the decode reads are kept
  scfp_pkg::frame_t frame_r;

  scfp_pkg::dec_t   dec;
  logic             in_acc;

  // output register plus one skid slot
  logic              out_valid_r;
  logic              out_valid_nxt;
  scfp_pkg::result_t out_r;
  scfp_pkg::result_t out_nxt;
  logic              skid_valid_r;
  logic              skid_valid_nxt;
  scfp_pkg::result_t skid_r;
  scfp_pkg::result_t skid_nxt;
  logic              new_res;
  logic              out_free;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;

  scfp_decode u_decode (
    .opcode    (in_opcode),
    .data_byte (in_data_byte),
    .ctl       (ctl_r),
    .frame     (frame_r),
    .dec       (dec)
  );

  // control state follows every accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (in_acc) begin
      ctl_r <= dec.ctl;
    end
  end

  // frame bytes, no reset: a byte is always written before it is read
  always_ff @(posedge clk) begin
    if (in_acc && dec.wr_en) begin
      frame_r[dec.wr_idx] <= in_data_byte;
    end
  end

  // output slot loads when empty or being taken; otherwise a new result parks in skid
  assign new_res  = in_acc && dec.res_valid;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = new_res;
        out_nxt       = dec.res;
      end
    end else if (new_res) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = dec.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = out_r.event_res;
  assign out_channel   = out_r.channel;
  assign out_position  = out_r.position;

endmodule

/* src/scfp_checker.sv */
// port-level checker for the servo command frame parser, bound to the top level
module scfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_event_res,
  input logic [1:0]  out_channel,
  input logic [15:0] out_position
);

  // a discard transaction carries zero channel and position
  a_discard_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == scfp_pkg::EV_DISCARD)
      |-> (out_channel == 2'd0) && (out_position == 16'd0))
    else $error("discard result with nonzero payload");

  // an update names an existing channel
  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == scfp_pkg::EV_UPDATE)
      |-> (32'(out_channel) < scfp_pkg::NUM_CHANNELS))
    else $error("update result with channel out of range");

  // input backpressure only while a result is waiting at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result visible after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_res)
      && $stable(out_channel) && $stable(out_position))
    else $error("stalled result changed");

endmodule

bind servo_command_frame_parser scfp_checker u_scfp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_event_res (out_event_res),
  .out_channel   (out_channel),
  .out_position  (out_position)
);
